>>> hdl/psa_pkg.sv
package psa_pkg;

  // Pool and map sizes
  localparam int POOL_SIZE    = 64;
  localparam int ENTITY_COUNT = 1024;
  localparam int MAX_RESULTS  = 64;

  // Slot index and link pointer widths; the pointer top bit means none
  localparam int SLOT_W = $clog2(POOL_SIZE);
  localparam int PTR_W  = SLOT_W + 1;
  localparam int MAP_AW = $clog2(ENTITY_COUNT);

  // Longest walk of one list request
  localparam int LIST_CNT = (MAX_RESULTS < POOL_SIZE) ? MAX_RESULTS : POOL_SIZE;
  localparam int K_W      = (LIST_CNT > 1) ? $clog2(LIST_CNT) : 1;

  localparam logic [PTR_W-1:0] PTR_NONE = {1'b1, {SLOT_W{1'b0}}};

  // Field widths of one word
  localparam int ENTITY_W = 10;
  localparam int AREA_W   = 16;
  localparam int FLAGS_W  = 2;
  localparam int OUT_SLOT_W = 6;

  // Request codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  // Contents held by one slot
  typedef struct packed {
    logic [ENTITY_W-1:0] entity;
    logic [AREA_W-1:0]   area;
    logic [FLAGS_W-1:0]  flags;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Write request into the entity map
  typedef struct packed {
    logic              we;
    logic [MAP_AW-1:0] addr;
    logic [PTR_W-1:0]  data;
  } map_wr_t;

endpackage

>>> hdl/psa_ram.sv
module psa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/psa_entity_map.sv
module psa_entity_map (
  input  logic             clk,
  input  logic             rst,
  input  psa_pkg::map_wr_t wr,
  output logic             clearing
);
  import psa_pkg::*;

  logic [PTR_W-1:0]  mem [ENTITY_COUNT];
  logic [MAP_AW-1:0] clr_addr;

  // Sweep the map once after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == MAP_AW'(ENTITY_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Write the cleared mark during the sweep, map updates afterwards
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= PTR_NONE;
    end else if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

endmodule

>>> hdl/pooled_slot_allocator_with_active_list.sv
// Pooled slot allocator with a LIFO free list and a doubly linked active list.
// Requests: a word is taken on a rising edge with start high and busy low.
//   op add    pops the free head, links it at the front of the active list and
//             stores entity, area and flags; the result follows in the next cycle.
//   op remove unlinks an active slot and pushes it on the free list; the result
//             comes from ST_REM_WB, or in the next cycle when the slot is not active.
//   op list   walks the active list from the front, one result word a cycle,
//             the first one from ST_LIST; last marks the final.
//   op code 3 is taken and gives no result.
// Results: done is high for one cycle per result word; the receiver cannot
// hold them off. busy stays high until the request has finished: an add
// through ST_ADD_WB, a remove through ST_REM_WB, a list through ST_LIST,
// while a failed request or op code 3 leaves the block idle. These states
// are needed because the link memories have registered reads.
// Reset (synchronous, active high) puts every slot on the free list, slot 0
// first, empties the active list, and starts a sweep of the entity map that
// keeps busy high until all ENTITY_COUNT (1024) entries are cleared.
module pooled_slot_allocator_with_active_list (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [9:0]  entity,
  input  logic [15:0] area,
  input  logic [1:0]  entry_flags,
  input  logic [5:0]  slot,
  output logic        done,
  output logic        ok,
  output logic [5:0]  slot_out,
  output logic [9:0]  entity_out,
  output logic [15:0] area_out,
  output logic [1:0]  flags_out,
  output logic        last
);
  import psa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ADD_WB = 4'b0010,
    ST_REM_WB = 4'b0100,
    ST_LIST   = 4'b1000
  } state_t;

  state_t state;

  logic [PTR_W-1:0]  free_head;
  logic [PTR_W-1:0]  active_head;
  logic [POOL_SIZE-1:0] slot_active;
  logic [POOL_SIZE-1:0] fn_valid;
  logic [SLOT_W-1:0] cur;
  logic [K_W-1:0]    k;

  // Memory ports
  logic              fn_we, an_we, ap_we, rec_we;
  logic [SLOT_W-1:0] fn_waddr, an_waddr, ap_waddr, rec_waddr;
  logic [PTR_W-1:0]  fn_wdata, an_wdata, ap_wdata;
  rec_t              rec_wdata;
  logic [SLOT_W-1:0] fn_raddr, an_raddr, ap_raddr, rec_raddr;
  logic [PTR_W-1:0]  fn_rdata, an_rdata, ap_rdata;
  logic [REC_W-1:0]  rec_rdata_bits;
  rec_t              rec_rdata;

  map_wr_t           map_wr;
  logic              clearing;

  logic              accept;
  logic              free_empty, head_none, ent_in_range, rem_ok, fin;
  logic [SLOT_W-1:0] fh_slot, ah_slot, slot_idx;
  logic [PTR_W-1:0]  fn_next_val;
  rec_t              rec_in;

  assign busy      = (state != ST_IDLE) || clearing;
  assign accept    = start && !busy;
  assign rec_rdata = rec_t'(rec_rdata_bits);

  assign free_empty   = free_head[PTR_W-1];
  assign head_none    = active_head[PTR_W-1];
  assign fh_slot      = free_head[SLOT_W-1:0];
  assign ah_slot      = active_head[SLOT_W-1:0];
  assign slot_idx     = SLOT_W'(slot);
  assign ent_in_range = 32'(entity) < ENTITY_COUNT;
  assign rem_ok       = (32'(slot) < POOL_SIZE) && slot_active[slot_idx];
  assign rec_in       = '{entity: entity, area: area, flags: entry_flags};

  // Successor on the free list; untouched entries keep their reset chain
  always_comb begin
    if (fn_valid[cur]) begin
      fn_next_val = fn_rdata;
    end else if (cur == SLOT_W'(POOL_SIZE - 1)) begin
      fn_next_val = PTR_NONE;
    end else begin
      fn_next_val = {1'b0, SLOT_W'(cur + 1'b1)};
    end
  end

  // End the walk at the list tail or at the result limit
  assign fin = an_rdata[PTR_W-1] || (k == K_W'(LIST_CNT - 1));

  // Drive memory reads and writes for each step
  always_comb begin
    fn_we = 1'b0; fn_waddr = '0; fn_wdata = '0; fn_raddr = fh_slot;
    an_we = 1'b0; an_waddr = '0; an_wdata = '0; an_raddr = ah_slot;
    ap_we = 1'b0; ap_waddr = '0; ap_wdata = '0; ap_raddr = slot_idx;
    rec_we = 1'b0; rec_waddr = '0; rec_wdata = '0; rec_raddr = ah_slot;
    map_wr = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_ADD: begin
              if (!free_empty) begin
                an_we     = 1'b1;
                an_waddr  = fh_slot;
                an_wdata  = active_head;
                rec_we    = 1'b1;
                rec_waddr = fh_slot;
                rec_wdata = rec_in;
                if (!head_none) begin
                  ap_we    = 1'b1;
                  ap_waddr = ah_slot;
                  ap_wdata = free_head;
                end
                map_wr.we   = ent_in_range;
                map_wr.addr = MAP_AW'(entity);
                map_wr.data = free_head;
              end
            end
            OP_REMOVE: begin
              an_raddr  = slot_idx;
              rec_raddr = slot_idx;
              if (rem_ok) begin
                fn_we    = 1'b1;
                fn_waddr = slot_idx;
                fn_wdata = free_head;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ADD_WB: begin
        fn_raddr = cur;
        ap_we    = 1'b1;
        ap_waddr = cur;
        ap_wdata = PTR_NONE;
      end
      ST_REM_WB: begin
        if (!ap_rdata[PTR_W-1]) begin
          an_we    = 1'b1;
          an_waddr = ap_rdata[SLOT_W-1:0];
          an_wdata = an_rdata;
        end
        if (!an_rdata[PTR_W-1]) begin
          ap_we    = 1'b1;
          ap_waddr = an_rdata[SLOT_W-1:0];
          ap_wdata = ap_rdata;
        end
        map_wr.we   = 32'(rec_rdata.entity) < ENTITY_COUNT;
        map_wr.addr = MAP_AW'(rec_rdata.entity);
        map_wr.data = PTR_NONE;
      end
      ST_LIST: begin
        an_raddr  = an_rdata[SLOT_W-1:0];
        rec_raddr = an_rdata[SLOT_W-1:0];
      end
      default: ;
    endcase
  end

  // Sequence requests and hold the list heads
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      free_head   <= '0;
      active_head <= PTR_NONE;
      slot_active <= '0;
      fn_valid    <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OP_ADD: begin
                done <= 1'b1;
                last <= 1'b1;
                if (free_empty) begin
                  ok <= 1'b0; slot_out <= '0;
                  entity_out <= '0; area_out <= '0; flags_out <= '0;
                end else begin
                  ok          <= 1'b1;
                  slot_out    <= OUT_SLOT_W'(fh_slot);
                  entity_out  <= entity;
                  area_out    <= area;
                  flags_out   <= entry_flags;
                  active_head <= free_head;
                  slot_active[fh_slot] <= 1'b1;
                  cur         <= fh_slot;
                  state       <= ST_ADD_WB;
                end
              end
              OP_REMOVE: begin
                if (rem_ok) begin
                  free_head <= {1'b0, slot_idx};
                  fn_valid[slot_idx]    <= 1'b1;
                  slot_active[slot_idx] <= 1'b0;
                  cur   <= slot_idx;
                  state <= ST_REM_WB;
                end else begin
                  done <= 1'b1; last <= 1'b1; ok <= 1'b0;
                  slot_out <= slot;
                  entity_out <= '0; area_out <= '0; flags_out <= '0;
                end
              end
              OP_LIST: begin
                if (head_none) begin
                  done <= 1'b1; last <= 1'b1; ok <= 1'b0; slot_out <= '0;
                  entity_out <= '0; area_out <= '0; flags_out <= '0;
                end else begin
                  cur   <= ah_slot;
                  k     <= '0;
                  state <= ST_LIST;
                end
              end
              default: ;
            endcase
          end
        end
        ST_ADD_WB: begin
          free_head <= fn_next_val;
          state     <= ST_IDLE;
        end
        ST_REM_WB: begin
          if (ap_rdata[PTR_W-1]) begin
            active_head <= an_rdata;
          end
          done       <= 1'b1;
          last       <= 1'b1;
          ok         <= 1'b1;
          slot_out   <= OUT_SLOT_W'(cur);
          entity_out <= rec_rdata.entity;
          area_out   <= rec_rdata.area;
          flags_out  <= rec_rdata.flags;
          state      <= ST_IDLE;
        end
        ST_LIST: begin
          done       <= 1'b1;
          last       <= fin;
          ok         <= 1'b1;
          slot_out   <= OUT_SLOT_W'(cur);
          entity_out <= rec_rdata.entity;
          area_out   <= rec_rdata.area;
          flags_out  <= rec_rdata.flags;
          if (fin) begin
            state <= ST_IDLE;
          end else begin
            cur <= an_rdata[SLOT_W-1:0];
            k   <= k + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  psa_ram #(.WIDTH(PTR_W), .DEPTH(POOL_SIZE)) u_free_next (
    .clk(clk), .we(fn_we), .waddr(fn_waddr), .wdata(fn_wdata),
    .raddr(fn_raddr), .rdata(fn_rdata)
  );

  psa_ram #(.WIDTH(PTR_W), .DEPTH(POOL_SIZE)) u_active_next (
    .clk(clk), .we(an_we), .waddr(an_waddr), .wdata(an_wdata),
    .raddr(an_raddr), .rdata(an_rdata)
  );

  psa_ram #(.WIDTH(PTR_W), .DEPTH(POOL_SIZE)) u_active_prev (
    .clk(clk), .we(ap_we), .waddr(ap_waddr), .wdata(ap_wdata),
    .raddr(ap_raddr), .rdata(ap_rdata)
  );

  psa_ram #(.WIDTH(REC_W), .DEPTH(POOL_SIZE)) u_record (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(REC_W'(rec_wdata)),
    .raddr(rec_raddr), .rdata(rec_rdata_bits)
  );

  psa_entity_map u_entity_map (
    .clk(clk), .rst(rst), .wr(map_wr), .clearing(clearing)
  );

  // An add always answers in the next cycle with a single word
  a_add_answers: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_ADD) |=> (done && last))
    else $error("add request gave no result word");

  // A list word that is not the last is followed at once by another
  a_list_continues: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |=> done)
    else $error("list walk stopped before its last word");

  // When idle, the free list is empty exactly when every slot is active
  a_pool_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (free_head[PTR_W-1] == ($countones(slot_active) == POOL_SIZE)))
    else $error("free list and active slots disagree");

  // A failed word is always the last of its request
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (last && state == ST_IDLE))
    else $error("failure word not final");

endmodule

>>> tb/tb_pooled_slot_allocator_with_active_list.sv
`timescale 1ns / 100ps

module tb_pooled_slot_allocator_with_active_list;
  import psa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  // One result word as seen on the outputs
  typedef struct packed {
    logic                ok;
    logic [5:0]          slot;
    logic [ENTITY_W-1:0] entity;
    logic [AREA_W-1:0]   area;
    logic [FLAGS_W-1:0]  flags;
    logic                last;
  } result_word_t;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  op = OP_ADD;
  logic [9:0]  entity = '0;
  logic [15:0] area = '0;
  logic [1:0]  entry_flags = '0;
  logic [5:0]  slot = '0;
  logic        busy;
  logic        done;
  logic        ok;
  logic [5:0]  slot_out;
  logic [9:0]  entity_out;
  logic [15:0] area_out;
  logic [1:0]  flags_out;
  logic        last;

  pooled_slot_allocator_with_active_list i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .entity      (entity),
    .area        (area),
    .entry_flags (entry_flags),
    .slot        (slot),
    .done        (done),
    .ok          (ok),
    .slot_out    (slot_out),
    .entity_out  (entity_out),
    .area_out    (area_out),
    .flags_out   (flags_out),
    .last        (last)
  );

  always #5 clk = ~clk;

  // Own copy of the pool: free list, active list and slot contents
  logic [PTR_W-1:0] free_head;
  logic [PTR_W-1:0] free_link [POOL_SIZE];
  logic [PTR_W-1:0] active_head;
  logic [PTR_W-1:0] active_link_next [POOL_SIZE];
  logic [PTR_W-1:0] active_link_prev [POOL_SIZE];
  logic             slot_in_use [POOL_SIZE];
  rec_t             slot_contents [POOL_SIZE];
  int               slots_in_use;

  result_word_t pending_words[$];

  int          error_count = 0;
  int          cycle_count = 0;
  bit          idle_on = 1'b1;
  int          n_add = 0, n_remove = 0, n_list = 0, n_ignored = 0;
  int          n_pool_empty = 0, n_bad_remove = 0, n_empty_list = 0;
  int          n_list_words = 0, n_longest_list = 0;

  // Hard limit on the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_error(input string what, input result_word_t want,
                              input result_word_t got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s want ok=%0b slot=%0d ent=%0d area=%h fl=%0d last=%0b",
               $realtime, what, want.ok, want.slot, want.entity, want.area,
               want.flags, want.last);
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s got  ok=%0b slot=%0d ent=%0d area=%h fl=%0d last=%0b",
               $realtime, what, got.ok, got.slot, got.entity, got.area,
               got.flags, got.last);
  endtask

  // Compare each word taken from the block with the oldest expected one
  always @(posedge clk) begin : result_checker
    result_word_t want;
    result_word_t got;
    if (!rst && done === 1'b1) begin
      got = '{ok, slot_out, entity_out, area_out, flags_out, last};
      if (pending_words.size() == 0) begin
        report_error("unexpected word", '0, got);
      end else begin
        want = pending_words.pop_front();
        if (got !== want)
          report_error("word mismatch", want, got);
      end
    end
  end

  task automatic clear_pool_model();
    free_head = '0;
    active_head = PTR_NONE;
    slots_in_use = 0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      free_link[i] = (i + 1 < POOL_SIZE) ? PTR_W'(i + 1) : PTR_NONE;
      active_link_next[i] = PTR_NONE;
      active_link_prev[i] = PTR_NONE;
      slot_in_use[i] = 1'b0;
      slot_contents[i] = '0;
    end
  endtask

  // Work out the words one accepted request gives and update the pool copy
  task automatic model_request(input logic [1:0] op_v, input logic [9:0] ent_v,
                               input logic [15:0] area_v, input logic [1:0] fl_v,
                               input logic [5:0] slot_v);
    logic [5:0]       s;
    logic [PTR_W-1:0] p;
    logic [PTR_W-1:0] n;
    logic [PTR_W-1:0] cur;
    logic             fin;
    int               k;
    case (op_v)
      OP_ADD: begin
        n_add++;
        if (free_head[PTR_W-1]) begin
          n_pool_empty++;
          pending_words.push_back('{1'b0, 6'd0, '0, '0, '0, 1'b1});
        end else begin
          s = free_head[SLOT_W-1:0];
          free_head = free_link[s];
          active_link_prev[s] = PTR_NONE;
          active_link_next[s] = active_head;
          if (!active_head[PTR_W-1])
            active_link_prev[active_head[SLOT_W-1:0]] = {1'b0, s};
          active_head = {1'b0, s};
          slot_in_use[s] = 1'b1;
          slots_in_use++;
          slot_contents[s] = '{ent_v, area_v, fl_v};
          pending_words.push_back('{1'b1, s, ent_v, area_v, fl_v, 1'b1});
        end
      end
      OP_REMOVE: begin
        n_remove++;
        s = slot_v;
        if (!slot_in_use[s]) begin
          n_bad_remove++;
          pending_words.push_back('{1'b0, s, '0, '0, '0, 1'b1});
        end else begin
          p = active_link_prev[s];
          n = active_link_next[s];
          if (!p[PTR_W-1])
            active_link_next[p[SLOT_W-1:0]] = n;
          else
            active_head = n;
          if (!n[PTR_W-1])
            active_link_prev[n[SLOT_W-1:0]] = p;
          free_link[s] = free_head;
          free_head = {1'b0, s};
          slot_in_use[s] = 1'b0;
          slots_in_use--;
          pending_words.push_back('{1'b1, s, slot_contents[s].entity,
                                    slot_contents[s].area, slot_contents[s].flags,
                                    1'b1});
        end
      end
      OP_LIST: begin
        n_list++;
        if (active_head[PTR_W-1]) begin
          n_empty_list++;
          pending_words.push_back('{1'b0, 6'd0, '0, '0, '0, 1'b1});
        end else begin
          // Walk from the front; the word count is capped at the longest walk
          cur = active_head;
          k = 0;
          fin = 1'b0;
          while (!fin) begin
            s = cur[SLOT_W-1:0];
            n = active_link_next[s];
            fin = n[PTR_W-1] || (k + 1 >= LIST_CNT);
            pending_words.push_back('{1'b1, s, slot_contents[s].entity,
                                      slot_contents[s].area, slot_contents[s].flags,
                                      fin});
            k++;
            cur = n;
          end
          n_list_words += k;
          if (k > n_longest_list)
            n_longest_list = k;
        end
      end
      default: n_ignored++;
    endcase
  endtask

  // Mostly short gaps, a few long ones, none while idling is off
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one word, hold it until taken, then predict and idle
  task automatic issue_request(input logic [1:0] op_v, input logic [9:0] ent_v,
                               input logic [15:0] area_v, input logic [1:0] fl_v,
                               input logic [5:0] slot_v);
    int unsigned gap;
    start <= 1'b1;
    op <= op_v;
    entity <= ent_v;
    area <= area_v;
    entry_flags <= fl_v;
    slot <= slot_v;
    @(posedge clk);
    while (busy) @(posedge clk);
    model_request(op_v, ent_v, area_v, fl_v, slot_v);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic add_random();
    issue_request(OP_ADD, 10'($urandom), 16'($urandom), 2'($urandom), 6'($urandom));
  endtask

  task automatic remove_slot(input logic [5:0] s);
    issue_request(OP_REMOVE, 10'($urandom), 16'($urandom), 2'($urandom), s);
  endtask

  task automatic list_active();
    issue_request(OP_LIST, 10'($urandom), 16'($urandom), 2'($urandom), 6'($urandom));
  endtask

  task automatic send_unused_op();
    issue_request(OP_UNUSED, 10'($urandom), 16'($urandom), 2'($urandom), 6'($urandom));
  endtask

  // Any slot now in use, starting the search at a random place
  function automatic logic [5:0] pick_active_slot();
    int base;
    base = $urandom_range(0, POOL_SIZE - 1);
    for (int i = 0; i < POOL_SIZE; i++)
      if (slot_in_use[(base + i) % POOL_SIZE])
        return 6'((base + i) % POOL_SIZE);
    return 6'(base);
  endfunction

  // Field extremes, link surgery at head, middle and tail, and the failures
  task automatic test_directed();
    list_active();
    remove_slot(6'd0);
    remove_slot(6'd63);
    issue_request(OP_ADD, 10'd0, 16'h0000, 2'd0, 6'd0);
    issue_request(OP_ADD, 10'd1023, 16'hffff, 2'd3, 6'd63);
    issue_request(OP_ADD, 10'd1023, 16'h1234, 2'd1, 6'd21);
    issue_request(OP_ADD, 10'd512, 16'h8000, 2'd2, 6'd42);
    send_unused_op();
    list_active();
    remove_slot(6'd1);
    remove_slot(6'd3);
    remove_slot(6'd0);
    remove_slot(6'd0);
    list_active();
    add_random();
    remove_slot(6'd2);
    remove_slot(6'd0);
    list_active();
    send_unused_op();
  endtask

  // Fill the pool, add past the end, list all of it, drain in random order
  task automatic test_pool_full();
    idle_on = 1'b0;
    while (slots_in_use < POOL_SIZE) add_random();
    idle_on = 1'b1;
    add_random();
    send_unused_op();
    list_active();
    while (slots_in_use > 0) remove_slot(pick_active_slot());
    remove_slot(6'($urandom));
    list_active();
  endtask

  // Alternate growing and shrinking phases with random content
  task automatic test_random_mix();
    int count;
    int unsigned r;
    int unsigned add_pct;
    for (int phase = 0; phase < 4; phase++) begin
      add_pct = phase[0] ? 25 : 55;
      idle_on = (phase != 2);
      count = 0;
      while (count < 65) begin
        r = $urandom_range(0, 99);
        if (r < add_pct) begin
          add_random();
        end else if (r < 85) begin
          if (slots_in_use > 0 && $urandom_range(0, 99) < 85)
            remove_slot(pick_active_slot());
          else
            remove_slot(6'($urandom));
        end else if (r < 96) begin
          list_active();
        end else begin
          send_unused_op();
          count--;
        end
        count++;
      end
    end
  endtask

  initial begin
    clear_pool_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_pool_full();
    test_random_mix();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("requests: %0d add (%0d pool empty), %0d remove (%0d bad), %0d ignored",
             n_add, n_pool_empty, n_remove, n_bad_remove, n_ignored);
    $display("lists: %0d (%0d empty), %0d listed words, longest %0d; %0d errors",
             n_list, n_empty_list, n_list_words, n_longest_list, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
